// ===== rtl/core/mac_frame_header_builder_assert.svh =====
// Assertion macros used by the MAC frame header builder controller.
`ifndef MAC_FRAME_HEADER_BUILDER_ASSERT_SVH
`define MAC_FRAME_HEADER_BUILDER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MFHB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MFHB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mfhb_pkg.sv =====
// Types and constants for the MAC frame header builder.
package mfhb_pkg;

  localparam int unsigned IDX_W = 5;

  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_SHORT = 2'd2;
  localparam logic [1:0] MODE_LONG  = 2'd3;

  localparam logic [IDX_W-1:0] FC_LEN    = 5'd3;
  localparam logic [IDX_W-1:0] PAN_LEN   = 5'd2;
  localparam logic [IDX_W-1:0] SHORT_LEN = 5'd2;
  localparam logic [IDX_W-1:0] LONG_LEN  = 5'd8;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SEND = 3'b010,
    ST_FAIL = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic fail;
  } cmd_t;

  typedef struct packed {
    logic too_small;
    logic last;
    logic first;
  } sts_t;

  function automatic logic [IDX_W-1:0] addr_len(input logic [1:0] mode);
    logic [IDX_W-1:0] len;
    unique case (mode)
      MODE_SHORT: len = SHORT_LEN;
      MODE_LONG:  len = LONG_LEN;
      default:    len = '0;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/core/mfhb_dp.sv =====
// Datapath: request registers, header layout, byte index and byte selection.
module mfhb_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [2:0]                in_frm_kind,
  input  logic                      in_ack_request,
  input  logic [1:0]                in_dst_mode,
  input  logic [1:0]                in_src_mode,
  input  logic                      in_dst_pan_on,
  input  logic                      in_src_pan_on,
  input  logic [15:0]               in_dst_pan,
  input  logic [15:0]               in_src_pan,
  input  logic [63:0]               in_dst_address,
  input  logic [63:0]               in_src_address,
  input  logic [7:0]                in_capacity,
  input  mfhb_pkg::cmd_t            cmd,
  output mfhb_pkg::sts_t            sts,
  output logic [7:0]                out_header_byte,
  output logic                      out_last_byte,
  output logic                      out_too_small,
  output logic [mfhb_pkg::IDX_W-1:0] out_hdr_len
);
  import mfhb_pkg::*;

  logic [2:0]       ftype_r;
  logic             ack_r;
  logic [1:0]       dmode_r;
  logic [1:0]       smode_r;
  logic             comp_r;
  logic [15:0]      dpan_r;
  logic [15:0]      span_r;
  logic [63:0]      daddr_r;
  logic [63:0]      saddr_r;
  logic [IDX_W-1:0] p_daddr_r;
  logic [IDX_W-1:0] p_span_r;
  logic [IDX_W-1:0] p_saddr_r;
  logic [IDX_W-1:0] len_r;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;

  logic             comp_in;
  logic [IDX_W-1:0] p_daddr_in;
  logic [IDX_W-1:0] p_span_in;
  logic [IDX_W-1:0] p_saddr_in;
  logic [IDX_W-1:0] len_in;
  logic [15:0]      fc;
  logic [IDX_W-1:0] off_dpan;
  logic [IDX_W-1:0] off_daddr;
  logic [IDX_W-1:0] off_span;
  logic [IDX_W-1:0] off_saddr;
  logic [7:0]       hdr_byte;

  assign comp_in = in_dst_pan_on && in_src_pan_on && (in_dst_mode != MODE_NONE)
                   && (in_src_mode != MODE_NONE) && (in_dst_pan == in_src_pan);

  assign p_daddr_in = FC_LEN + (in_dst_pan_on ? PAN_LEN : '0);
  assign p_span_in  = p_daddr_in + addr_len(in_dst_mode);
  assign p_saddr_in = p_span_in + ((in_src_pan_on && !comp_in) ? PAN_LEN : '0);
  assign len_in     = p_saddr_in + addr_len(in_src_mode);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ftype_r   <= in_frm_kind;
      ack_r     <= in_ack_request;
      dmode_r   <= in_dst_mode;
      smode_r   <= in_src_mode;
      comp_r    <= comp_in;
      dpan_r    <= in_dst_pan;
      span_r    <= in_src_pan;
      daddr_r   <= in_dst_address;
      saddr_r   <= in_src_address;
      p_daddr_r <= p_daddr_in;
      p_span_r  <= p_span_in;
      p_saddr_r <= p_saddr_in;
      len_r     <= len_in;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    priority if (cmd.load) begin
      idx_nxt = '0;
    end else if (cmd.step) begin
      idx_nxt = (idx_r == len_r - 5'd1) ? '0 : idx_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  assign fc        = {smode_r, 2'b00, dmode_r, 2'b00, 1'b0, comp_r, ack_r, 2'b00, ftype_r};
  assign off_dpan  = idx_r - FC_LEN;
  assign off_daddr = idx_r - p_daddr_r;
  assign off_span  = idx_r - p_span_r;
  assign off_saddr = idx_r - p_saddr_r;

  always_comb begin
    priority if (idx_r == 5'd0) begin
      hdr_byte = fc[7:0];
    end else if (idx_r == 5'd1) begin
      hdr_byte = fc[15:8];
    end else if (idx_r == 5'd2) begin
      hdr_byte = 8'h00;
    end else if (idx_r < p_daddr_r) begin
      hdr_byte = off_dpan[0] ? dpan_r[15:8] : dpan_r[7:0];
    end else if (idx_r < p_span_r) begin
      hdr_byte = daddr_r[{off_daddr[2:0], 3'b000} +: 8];
    end else if (idx_r < p_saddr_r) begin
      hdr_byte = off_span[0] ? span_r[15:8] : span_r[7:0];
    end else begin
      hdr_byte = saddr_r[{off_saddr[2:0], 3'b000} +: 8];
    end
  end

  assign sts.too_small = {3'b000, len_in} > in_capacity;
  assign sts.last      = (idx_r == len_r - 5'd1);
  assign sts.first     = (idx_r == '0);

  assign out_header_byte = cmd.fail ? 8'h00 : hdr_byte;
  assign out_last_byte   = cmd.fail | sts.last;
  assign out_too_small   = cmd.fail;
  assign out_hdr_len     = cmd.fail ? '0 : len_r;

endmodule

// ===== rtl/core/mfhb_ctrl.sv =====
// Controller: accepts a request, then sequences the header bytes or the error result.
`include "mac_frame_header_builder_assert.svh"

module mfhb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  mfhb_pkg::sts_t sts,
  output mfhb_pkg::cmd_t cmd
);
  import mfhb_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   in_acc;
  logic   out_acc;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_SEND) || (state_r == ST_FAIL);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  assign cmd.load = in_acc;
  assign cmd.step = (state_r == ST_SEND) && out_acc;
  assign cmd.fail = (state_r == ST_FAIL);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.too_small ? ST_FAIL : ST_SEND;
        end
      end
      ST_SEND: begin
        if (!out_stall && sts.last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FAIL: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `MFHB_ASSERT_NEXT(a_accept_starts_output, clk, rst_n, in_acc, out_valid, "no result after accepted request")
  `MFHB_ASSERT_NEXT(a_accept_resets_index, clk, rst_n, in_acc, sts.first, "byte index not cleared on accept")
  `MFHB_ASSERT_NEXT(a_last_returns_idle, clk, rst_n, out_acc && (cmd.fail || sts.last), !out_valid && !in_stall, "block not idle after final result")
  `MFHB_ASSERT_SAME(a_fail_single, clk, rst_n, cmd.fail, sts.first, "error result with nonzero byte index")

endmodule

// ===== rtl/core/mac_frame_header_builder.sv =====
// Top level of the IEEE 802.15.4 MAC frame header builder.
// Latency: the first header byte, or the error result, is valid the cycle after the request is accepted.
// Throughput: one byte per cycle while out_stall is low; a request yields a header of
// 3 to 23 bytes, an undersized request one error result.
// The next request is accepted only after the final result has been taken.
// Reset (rst_n low, synchronous) returns the controller to idle and clears the byte index.
module mac_frame_header_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_frm_kind,
  input  logic        in_ack_request,
  input  logic [1:0]  in_dst_mode,
  input  logic [1:0]  in_src_mode,
  input  logic        in_dst_pan_on,
  input  logic        in_src_pan_on,
  input  logic [15:0] in_dst_pan,
  input  logic [15:0] in_src_pan,
  input  logic [63:0] in_dst_address,
  input  logic [63:0] in_src_address,
  input  logic [7:0]  in_capacity,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_header_byte,
  output logic        out_last_byte,
  output logic        out_too_small,
  output logic [4:0]  out_hdr_len
);
  import mfhb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mfhb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mfhb_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_frm_kind        (in_frm_kind),
    .in_ack_request     (in_ack_request),
    .in_dst_mode        (in_dst_mode),
    .in_src_mode        (in_src_mode),
    .in_dst_pan_on      (in_dst_pan_on),
    .in_src_pan_on      (in_src_pan_on),
    .in_dst_pan         (in_dst_pan),
    .in_src_pan         (in_src_pan),
    .in_dst_address     (in_dst_address),
    .in_src_address     (in_src_address),
    .in_capacity        (in_capacity),
    .cmd                (cmd),
    .sts                (sts),
    .out_header_byte    (out_header_byte),
    .out_last_byte      (out_last_byte),
    .out_too_small      (out_too_small),
    .out_hdr_len        (out_hdr_len)
  );

endmodule
